// ===== sv/csna_pkg.sv =====
// Shared constants and controller/datapath interface types for the stencil block.
`timescale 1ns / 1ps

package csna_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int SAMPLE_BITS = 32;
    localparam int CFG_BITS    = 9;
    localparam int AVG_BITS    = 32;
    localparam int CNT_BITS    = 3;
    localparam int LINE_DEPTH  = MAX_WIDTH + 2;
    localparam int ADDR_BITS   = $clog2(LINE_DEPTH);
    localparam logic [CFG_BITS-1:0] WIDTH_RESET = CFG_BITS'(16);

    // four-sample sum and the split used by the divide-by-three stages
    localparam int SUM_BITS = SAMPLE_BITS + 2;
    localparam int LO_BITS  = SUM_BITS / 2;
    localparam int HI_BITS  = SUM_BITS - LO_BITS;

    // reciprocals of three, rounded up, for the upper and lower halves
    localparam longint unsigned K_HI_VAL = ((64'd1 << (HI_BITS + 2)) + 64'd2) / 3;
    localparam longint unsigned K_LO_VAL = ((64'd1 << (LO_BITS + 4)) + 64'd2) / 3;

    // per-transfer command from the controller
    typedef struct packed {
        logic                 take;
        logic [ADDR_BITS-1:0] addr;
        logic                 emit;
        logic                 done;
    } t_cmd;

    // datapath status back to the controller
    typedef struct packed {
        logic advance;
    } t_status;

endpackage

// ===== sv/csna_ctrl.sv =====
// Controller: width register, raster position counters and transfer commands.
`timescale 1ns / 1ps

module csna_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              i_cfg_we,
    input  logic [csna_pkg::CFG_BITS-1:0]     i_cfg_data,
    input  csna_pkg::t_status                 i_status,
    output logic                              o_stall,
    output csna_pkg::t_cmd                    o_cmd
);

    typedef enum logic [1:0] {
        ST_PRIME  = 2'b01,
        ST_STREAM = 2'b10
    } t_state;

    t_state                            r_state, n_state;
    logic [csna_pkg::CFG_BITS-1:0]     r_width, n_width;
    logic [csna_pkg::ADDR_BITS-1:0]    r_row, n_row;
    logic [csna_pkg::ADDR_BITS-1:0]    r_col, n_col;
    logic [csna_pkg::ADDR_BITS-1:0]    w_eff;
    logic [csna_pkg::ADDR_BITS-1:0]    w_last;
    logic                              w_take;

    // out-of-range widths clamp to 1 .. MAX_WIDTH
    always_comb begin
        if (r_width == '0) begin
            w_eff = csna_pkg::ADDR_BITS'(1);
        end else if (int'(r_width) > csna_pkg::MAX_WIDTH) begin
            w_eff = csna_pkg::ADDR_BITS'(csna_pkg::MAX_WIDTH);
        end else begin
            w_eff = csna_pkg::ADDR_BITS'(r_width);
        end
    end
    assign w_last = w_eff + csna_pkg::ADDR_BITS'(1);

    assign o_stall = !i_status.advance;
    assign w_take  = i_valid && i_status.advance && !i_cfg_we;

    assign o_cmd.take = w_take;
    assign o_cmd.addr = r_col;
    assign o_cmd.emit = (r_state == ST_STREAM) && (r_col >= csna_pkg::ADDR_BITS'(2));
    assign o_cmd.done = (r_row == w_last) && (r_col == w_last);

    always_comb begin
        n_state = r_state;
        n_width = r_width;
        n_row   = r_row;
        n_col   = r_col;
        if (i_cfg_we) begin
            n_width = i_cfg_data;
            n_row   = '0;
            n_col   = '0;
            n_state = ST_PRIME;
        end else if (w_take) begin
            if (r_col == w_last) begin
                n_col = '0;
                if (r_row == w_last) begin
                    n_row   = '0;
                    n_state = ST_PRIME;
                end else begin
                    n_row = r_row + csna_pkg::ADDR_BITS'(1);
                    // two rows buffered: results start with the third padded row
                    if (r_row == csna_pkg::ADDR_BITS'(1)) begin
                        n_state = ST_STREAM;
                    end
                end
            end else begin
                n_col = r_col + csna_pkg::ADDR_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_PRIME;
            r_width <= csna_pkg::WIDTH_RESET;
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_width <= n_width;
            r_row   <= n_row;
            r_col   <= n_col;
        end
    end

endmodule

// ===== sv/csna_datapath.sv =====
// Datapath: two line buffers, stencil window, sum/count and divide pipeline.
`timescale 1ns / 1ps

module csna_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  csna_pkg::t_cmd                      i_cmd,
    input  logic [csna_pkg::SAMPLE_BITS-1:0]    i_sample,
    input  logic                                i_stall,
    output csna_pkg::t_status                   o_status,
    output logic                                o_valid,
    output logic [csna_pkg::AVG_BITS-1:0]       o_average,
    output logic [csna_pkg::CNT_BITS-1:0]       o_neighbours_used,
    output logic                                o_tile_done
);

    localparam int SB = csna_pkg::SAMPLE_BITS;
    localparam int SU = csna_pkg::SUM_BITS;
    localparam int LB = csna_pkg::LO_BITS;
    localparam int HB = csna_pkg::HI_BITS;
    localparam int CB = csna_pkg::CNT_BITS;
    localparam int AB = csna_pkg::ADDR_BITS;
    localparam int PH = 2 * HB + 2;
    localparam int PL = 2 * LB + 5;
    localparam logic [HB+1:0] K_HI = (HB + 2)'(csna_pkg::K_HI_VAL);
    localparam logic [LB+2:0] K_LO = (LB + 3)'(csna_pkg::K_LO_VAL);

    // mem_prev holds row r-1, mem_old holds row r-2
    logic [SB-1:0] mem_prev [csna_pkg::LINE_DEPTH];
    logic [SB-1:0] mem_old  [csna_pkg::LINE_DEPTH];

    logic          w_adv;

    // stage 1: line reads land, window shifts
    logic          r_s1_valid;
    logic [SB-1:0] r_s1_sample;
    logic [AB-1:0] r_s1_addr;
    logic          r_s1_emit;
    logic          r_s1_done;
    logic [SB-1:0] r_rd_prev;
    logic [SB-1:0] r_rd_old;
    logic [SB-1:0] r_up;
    logic [SB-1:0] r_down;
    logic [SB-1:0] r_mid1;
    logic [SB-1:0] r_mid2;

    // stage 2: sum and count
    logic          r_s2_valid;
    logic [SU-1:0] r_s2_sum;
    logic [CB-1:0] r_s2_cnt;
    logic          r_s2_done;

    // stage 3: upper half divided by three
    logic          r_s3_valid;
    logic [SU-1:0] r_s3_sum;
    logic [CB-1:0] r_s3_cnt;
    logic          r_s3_done;
    logic [HB-1:0] r_s3_qh;
    logic [1:0]    r_s3_rh;
    logic [LB-1:0] r_s3_xl;

    // output register
    logic          r_out_valid;
    logic [csna_pkg::AVG_BITS-1:0] r_out_avg;
    logic [CB-1:0] r_out_cnt;
    logic          r_out_done;

    logic [SU-1:0] w_sum;
    logic [CB-1:0] w_cnt;
    logic [HB-1:0] w_xh;
    logic [PH-1:0] w_prod_hi;
    logic [HB-1:0] w_qh;
    logic [HB-1:0] w_rh_full;
    logic [LB+1:0] w_y;
    logic [PL-1:0] w_prod_lo;
    logic [LB-1:0] w_ql;
    logic [SU-1:0] w_mean;

    // the whole pipe holds while a finished result is stalled
    assign w_adv = !(r_out_valid && i_stall);
    assign o_status.advance = w_adv;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (i_cmd.take) begin
                r_rd_prev <= mem_prev[i_cmd.addr];
                r_rd_old  <= mem_old[i_cmd.addr];
            end
            if (r_s1_valid) begin
                mem_prev[r_s1_addr] <= r_s1_sample;
                mem_old[r_s1_addr]  <= r_rd_prev;
            end
        end
    end

    always_comb begin
        w_sum = SU'(r_up) + SU'(r_down) + SU'(r_mid2) + SU'(r_rd_prev);
        w_cnt = CB'(r_up != '0) + CB'(r_down != '0) + CB'(r_mid2 != '0)
              + CB'(r_rd_prev != '0);
    end

    always_comb begin
        w_xh      = r_s2_sum[SU-1:LB];
        w_prod_hi = PH'(w_xh) * PH'(K_HI);
        w_qh      = w_prod_hi[PH-1:HB+2];
        w_rh_full = w_xh - ((w_qh << 1) + w_qh);
    end

    always_comb begin
        w_y       = {r_s3_rh, r_s3_xl};
        w_prod_lo = PL'(w_y) * PL'(K_LO);
        w_ql      = w_prod_lo[2*LB+3:LB+4];
        case (r_s3_cnt)
            CB'(1):  w_mean = r_s3_sum;
            CB'(2):  w_mean = r_s3_sum >> 1;
            CB'(3):  w_mean = {r_s3_qh, w_ql};
            CB'(4):  w_mean = r_s3_sum >> 2;
            default: w_mean = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid  <= i_cmd.take;
            r_s2_valid  <= r_s1_valid && r_s1_emit;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_sample <= i_sample;
            r_s1_addr   <= i_cmd.addr;
            r_s1_emit   <= i_cmd.emit;
            r_s1_done   <= i_cmd.done;
            if (r_s1_valid) begin
                r_up   <= r_rd_old;
                r_down <= r_s1_sample;
                r_mid2 <= r_mid1;
                r_mid1 <= r_rd_prev;
            end
            r_s2_sum  <= w_sum;
            r_s2_cnt  <= w_cnt;
            r_s2_done <= r_s1_done;
            r_s3_sum  <= r_s2_sum;
            r_s3_cnt  <= r_s2_cnt;
            r_s3_done <= r_s2_done;
            r_s3_qh   <= w_qh;
            r_s3_rh   <= w_rh_full[1:0];
            r_s3_xl   <= r_s2_sum[LB-1:0];
            r_out_avg  <= w_mean[csna_pkg::AVG_BITS-1:0];
            r_out_cnt  <= r_s3_cnt;
            r_out_done <= r_s3_done;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_average         = r_out_avg;
    assign o_neighbours_used = r_out_cnt;
    assign o_tile_done       = r_out_done;

endmodule

// ===== sv/cross_stencil_nonzero_average_top.sv =====
// Top level of the cross-stencil nonzero-average block.
//
// Usage:
//   Input channel (i_valid / o_stall / i_sample): one padded-tile sample per
//   transfer, raster order, (tile_width+2) squared samples per tile. Tiles
//   follow each other with no gap.
//   Output channel (o_valid / i_stall / o_average, o_neighbours_used,
//   o_tile_done): one result per interior cell, emitted while the row below
//   it streams in. Halo samples and the first two padded rows give none.
//   Config: i_cfg_we / i_cfg_data write tile_width (0 acts as 1, values above
//   MAX_WIDTH clamp to it); a write restarts the tile.
//   Throughput: one sample per cycle while o_stall is low, limited by the
//   single read and write port of each line buffer. Pipeline: a result passes
//   the stage 1, sum, divide and output registers before it is on o_valid.
//   Stall: while a result sits on the output and i_stall is high, the whole
//   pipeline holds and o_stall is raised; otherwise o_stall stays low.
//   Reset: synchronous, active low; clears the pipeline, restarts the tile
//   and sets tile_width to 16. Line buffers are not cleared: every entry is
//   rewritten during the first two rows of a tile before it is read.
`timescale 1ns / 1ps

module cross_stencil_nonzero_average_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [csna_pkg::SAMPLE_BITS-1:0]    i_sample,
    input  logic                                i_cfg_we,
    input  logic [csna_pkg::CFG_BITS-1:0]       i_cfg_data,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [csna_pkg::AVG_BITS-1:0]       o_average,
    output logic [csna_pkg::CNT_BITS-1:0]       o_neighbours_used,
    output logic                                o_tile_done
);

    csna_pkg::t_cmd    w_cmd;
    csna_pkg::t_status w_status;

    // position tracking and the accept decision
    csna_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_status   (w_status),
        .o_stall    (o_stall),
        .o_cmd      (w_cmd)
    );

    // line buffers, window and averaging pipe
    csna_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_sample          (i_sample),
        .i_stall           (i_stall),
        .o_status          (w_status),
        .o_valid           (o_valid),
        .o_average         (o_average),
        .o_neighbours_used (o_neighbours_used),
        .o_tile_done       (o_tile_done)
    );

endmodule

// ===== sv/csna_checker.sv =====
// Port-level checker for the stencil block, bound to the top level.
`timescale 1ns / 1ps

module csna_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_stall,
    input logic [csna_pkg::SAMPLE_BITS-1:0]    i_sample,
    input logic                                i_cfg_we,
    input logic [csna_pkg::CFG_BITS-1:0]       i_cfg_data,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic [csna_pkg::AVG_BITS-1:0]       o_average,
    input logic [csna_pkg::CNT_BITS-1:0]       o_neighbours_used,
    input logic                                o_tile_done
);

    // a stalled result holds until transferred
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_average)
            && $stable(o_neighbours_used) && $stable(o_tile_done))
        else $error("stalled result changed");

    // input is held back only by a result waiting on a stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held result");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_neighbours_used <= csna_pkg::CNT_BITS'(4))
        else $error("neighbour count out of range");

    a_zero_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_neighbours_used == '0 |-> o_average == '0)
        else $error("nonzero average with no neighbours");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind cross_stencil_nonzero_average_top csna_checker u_checker (.*);
